### rtl/agms_pkg.sv
// ----------------------------------------------------------------------------
// agms_pkg
// Shared types, widths and helpers for the greedy argmax action selector.
// ----------------------------------------------------------------------------
package agms_pkg;

    localparam int Q_W        = 32;  // q-value, signed q16.16
    localparam int ACT_W      = 6;   // action index
    localparam int PROB_W     = 17;  // probability, unsigned q1.16
    localparam int CNT_W      = 7;   // counts of actions and ties, 0..64
    localparam int SEED_W     = 16;
    localparam int DIVD_W     = 17;  // dividend of the serial divider
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - ACT_W - PROB_W - CNT_W;

    localparam logic [DIVD_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE = 1'b0,
        CFG_SEED = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        MODE_PICK = 1'b0,
        MODE_DIST = 1'b1
    } sel_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_MOD,
        ST_READ,
        ST_PUT
    } emit_state_t;

    // one finished run, handed from the loader to the emitter
    typedef struct packed {
        sel_mode_t               mode;
        logic                    bank;
        logic [CNT_W-1:0]        count;
        logic [CNT_W-1:0]        ties;
        logic signed [Q_W-1:0]   best;
    } run_desc_t;

    // store write port driven by the loader
    typedef struct packed {
        logic                val_we;
        logic                tie_we;
        logic                bank;
        logic [ACT_W-1:0]    val_idx;
        logic [Q_W-1:0]      val_data;
        logic [ACT_W-1:0]    tie_idx;
        logic [ACT_W-1:0]    tie_data;
    } store_wr_t;

    // x^16+x^14+x^13+x^11+1, shifting right, feedback into bit 15
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[SEED_W-1:1]};
    endfunction

endpackage

### rtl/agms_front.sv
// ----------------------------------------------------------------------------
// agms_front
// Loader: takes q-values, tracks the running maximum and its ties, writes
// the stores and pushes a run descriptor on the last item.
// ----------------------------------------------------------------------------
module agms_front import agms_pkg::*; #(
    parameter int MAX_ACTIONS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic signed [Q_W-1:0] q_value,
    input  logic                  last,
    input  sel_mode_t             mode,
    input  logic                  queue_full,
    output logic                  push,
    output run_desc_t             desc,
    output store_wr_t             wr
);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      ties_reg, ties_next;
    logic signed [Q_W-1:0] best_reg, best_next;
    logic                  bank_reg, bank_next;
    logic                  accept;
    logic                  room;

    // a bank is only reused once the emitter has released it
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign room     = count_reg < CNT_W'(MAX_ACTIONS);

    always_comb begin
        count_next  = count_reg;
        ties_next   = ties_reg;
        best_next   = best_reg;
        bank_next   = bank_reg;
        push        = 1'b0;
        wr          = '0;
        wr.bank     = bank_reg;
        wr.val_idx  = count_reg[ACT_W-1:0];
        wr.val_data = q_value;
        wr.tie_data = count_reg[ACT_W-1:0];

        if (accept && room) begin
            wr.val_we  = 1'b1;
            count_next = count_reg + CNT_W'(1);
            if (count_reg == '0 || q_value > best_reg) begin
                best_next  = q_value;
                ties_next  = CNT_W'(1);
                wr.tie_we  = 1'b1;
                wr.tie_idx = '0;
            end else if (q_value == best_reg) begin
                ties_next  = ties_reg + CNT_W'(1);
                wr.tie_we  = 1'b1;
                wr.tie_idx = ties_reg[ACT_W-1:0];
            end
        end

        desc.mode  = mode;
        desc.bank  = bank_reg;
        desc.count = count_next;
        desc.ties  = ties_next;
        desc.best  = best_next;

        if (accept && last) begin
            push       = 1'b1;
            count_next = '0;
            ties_next  = '0;
            best_next  = '0;
            bank_next  = ~bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ties_reg  <= '0;
            best_reg  <= '0;
            bank_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            ties_reg  <= ties_next;
            best_reg  <= best_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

### rtl/agms_fifo.sv
// ----------------------------------------------------------------------------
// agms_fifo
// Two-entry queue of finished runs between loader and emitter.
// ----------------------------------------------------------------------------
module agms_fifo import agms_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  run_desc_t din,
    input  logic      pop,
    output run_desc_t dout,
    output logic      empty,
    output logic      full
);

    run_desc_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign dout  = entry_reg[rd_ptr_reg];
    assign empty = fill_reg == 2'd0;
    assign full  = fill_reg == 2'd2;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

### rtl/agms_div.sv
// ----------------------------------------------------------------------------
// agms_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agms_div import agms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient,
    output logic [CNT_W-1:0]  remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIVD_W-1:0]    quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsr_reg;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;
    logic                 fits;

    assign shifted   = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits      = shifted >= {1'b0, dsr_reg};
    assign diff      = shifted - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits the divisor width
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

endmodule

### rtl/agms_back.sv
// ----------------------------------------------------------------------------
// agms_back
// Emitter: holds the two-bank stores, computes the reciprocal and the random
// pick on a shared divider, and drives the result register.
// ----------------------------------------------------------------------------
module agms_back import agms_pkg::*; #(
    parameter int MAX_ACTIONS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  store_wr_t          wr,
    input  run_desc_t          desc,
    input  logic               q_empty,
    output logic               pop,
    input  logic               seed_we,
    input  logic [SEED_W-1:0]  seed_value,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [ACT_W-1:0]   action_index,
    output logic [PROB_W-1:0]  probability,
    output logic [CNT_W-1:0]   tie_count,
    output logic               last_out
);

    localparam int IDX_W     = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int MEM_DEPTH = 2 * (1 << IDX_W);

    logic [Q_W-1:0]   value_mem [MEM_DEPTH];
    logic [ACT_W-1:0] tied_mem  [MEM_DEPTH];

    emit_state_t       state_reg, state_next;
    run_desc_t         run_reg;
    logic              run_latch;
    logic [PROB_W-1:0] recip_reg, recip_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [SEED_W-1:0] lfsr_reg, lfsr_next;
    logic [Q_W-1:0]    val_rd_reg;
    logic [ACT_W-1:0]  tie_rd_reg;
    logic              val_rd_en;
    logic              tie_rd_en;
    logic [IDX_W-1:0]  rd_idx;

    logic              out_valid_reg;
    logic [ACT_W-1:0]  out_idx_reg, out_idx_next;
    logic [PROB_W-1:0] out_prob_reg, out_prob_next;
    logic [CNT_W-1:0]  out_ties_reg;
    logic              out_last_reg, out_last_next;
    logic              load_out;
    logic              can_load;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [CNT_W-1:0]  div_rem;

    agms_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // stores: bank bit on top of the action index
    always_ff @(posedge aclk) begin
        if (wr.val_we) begin
            value_mem[{wr.bank, wr.val_idx[IDX_W-1:0]}] <= wr.val_data;
        end
        if (val_rd_en) begin
            val_rd_reg <= value_mem[{run_reg.bank, rd_idx}];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.tie_we) begin
            tied_mem[{wr.bank, wr.tie_idx[IDX_W-1:0]}] <= wr.tie_data;
        end
        if (tie_rd_en) begin
            tie_rd_reg <= tied_mem[{run_reg.bank, rd_idx}];
        end
    end

    assign can_load = !out_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        run_latch     = 1'b0;
        recip_next    = recip_reg;
        k_next        = k_reg;
        lfsr_next     = lfsr_reg;
        val_rd_en     = 1'b0;
        tie_rd_en     = 1'b0;
        rd_idx        = k_reg[IDX_W-1:0];
        div_start     = 1'b0;
        div_dividend  = ONE_Q16 + DIVD_W'(run_reg.ties >> 1);
        div_divisor   = run_reg.ties;
        pop           = 1'b0;
        load_out      = 1'b0;
        out_idx_next  = k_reg[ACT_W-1:0];
        out_prob_next = recip_reg;
        out_last_next = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    run_latch    = 1'b1;
                    div_start    = 1'b1;
                    div_dividend = ONE_Q16 + DIVD_W'(desc.ties >> 1);
                    div_divisor  = desc.ties;
                    state_next   = ST_RECIP;
                end
            end
            ST_RECIP: begin
                if (div_done) begin
                    recip_next = div_quo[PROB_W-1:0];
                    if (run_reg.mode == MODE_PICK) begin
                        lfsr_next    = lfsr_step(lfsr_reg);
                        div_start    = 1'b1;
                        div_dividend = DIVD_W'(lfsr_step(lfsr_reg));
                        state_next   = ST_MOD;
                    end else begin
                        k_next     = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    tie_rd_en  = 1'b1;
                    rd_idx     = div_rem[IDX_W-1:0];
                    state_next = ST_PUT;
                end
            end
            ST_READ: begin
                val_rd_en  = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (can_load) begin
                    load_out = 1'b1;
                    if (run_reg.mode == MODE_PICK) begin
                        out_idx_next = tie_rd_reg;
                        pop          = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        out_prob_next = (val_rd_reg == run_reg.best) ? recip_reg : '0;
                        out_last_next = (k_reg + CNT_W'(1)) == run_reg.count;
                        if (out_last_next) begin
                            pop        = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            k_next     = k_reg + CNT_W'(1);
                            state_next = ST_READ;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lfsr_reg      <= SEED_RESET;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // an all-zero seed would lock the lfsr
            if (seed_we) begin
                lfsr_reg <= (seed_value == '0) ? SEED_RESET : seed_value;
            end else begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (run_latch) begin
            run_reg <= desc;
        end
        recip_reg <= recip_next;
        k_reg     <= k_next;
        if (load_out) begin
            out_idx_reg  <= out_idx_next;
            out_prob_reg <= out_prob_next;
            out_ties_reg <= run_reg.ties;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign action_index = out_idx_reg;
    assign probability  = out_prob_reg;
    assign tie_count    = out_ties_reg;
    assign last_out     = out_last_reg;

endmodule

### rtl/greedy_argmax_action_selector_unit.sv
// ----------------------------------------------------------------------------
// greedy_argmax_action_selector_unit
// Argmax over one state's q-values with a uniform random tie break.
// ----------------------------------------------------------------------------
// Usage: feed the q-values of one state's actions on the s_ stream in action
// order, one item each, tlast on the final action. Values beyond MAX_ACTIONS
// are ignored. The m_ stream then gives one item in pick mode (a tied action
// chosen by a 16-bit lfsr, tlast set) or one item per stored action in
// distribution mode (1/ties for tied actions, zero otherwise, tlast on the
// final one). Configuration writes go through cfg_we/cfg_addr/cfg_wdata and
// must only be made while no run is in flight.
// Throughput: loading takes one item per cycle while s_tready is high. After
// tlast the emitter computes the reciprocal 1/ties in the serial divider; pick
// mode then divides the stepped lfsr value by ties on the same divider and reads
// the tied index at the remainder; distribution mode reads one stored value per
// item. The stores have two banks and the run queue two entries, so the
// next run loads while the previous one is emitted.
// Reset clears run state, sets mode to pick and the lfsr to 1. When m_tready
// is low the result is held and the emitter waits; the loader keeps taking
// items until both banks are busy.
// ----------------------------------------------------------------------------
module greedy_argmax_action_selector_unit import agms_pkg::*; #(
    parameter int MAX_ACTIONS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] q_value
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [5:0] action_index, [22:6] probability,
                                             // [29:23] tie_count, [31:30] zero
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SEED_W-1:0]     cfg_wdata
);

    sel_mode_t         mode_reg;
    logic              seed_we;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;
    run_desc_t         q_din;
    run_desc_t         q_dout;
    store_wr_t         store_wr;
    logic [ACT_W-1:0]  action_index;
    logic [PROB_W-1:0] probability;
    logic [CNT_W-1:0]  tie_count;

    assign seed_we = cfg_we && (cfg_reg_t'(cfg_addr) == CFG_SEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PICK;
        end else if (cfg_we && (cfg_reg_t'(cfg_addr) == CFG_MODE)) begin
            mode_reg <= sel_mode_t'(cfg_wdata[0]);
        end
    end

    agms_front #(
        .MAX_ACTIONS (MAX_ACTIONS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .q_value    (s_tdata[Q_W-1:0]),
        .last       (s_tlast),
        .mode       (mode_reg),
        .queue_full (q_full),
        .push       (q_push),
        .desc       (q_din),
        .wr         (store_wr)
    );

    agms_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty),
        .full    (q_full)
    );

    agms_back #(
        .MAX_ACTIONS (MAX_ACTIONS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr           (store_wr),
        .desc         (q_dout),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .seed_we      (seed_we),
        .seed_value   (cfg_wdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .action_index (action_index),
        .probability  (probability),
        .tie_count    (tie_count),
        .last_out     (m_tlast)
    );

    assign m_tdata = {M_PAD_W'(0), tie_count, probability, action_index};

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("run queue overflow");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("run queue underflow");

    a_ties_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (tie_count != '0) && (tie_count <= CNT_W'(MAX_ACTIONS)))
        else $error("tie count out of range");

endmodule
